// ----- rtl/ubbm_pkg.sv -----
// Shared types and constants for the serial bus bridge master.
// Used by ubbm_front, ubbm_queue, ubbm_back and uart_bus_bridge_master.
package ubbm_pkg;

    typedef enum logic [1:0] {
        MODE_START = 2'd0,
        MODE_DATA  = 2'd1,
        MODE_RX    = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        OP_READ_WORD  = 2'd0,
        OP_WRITE_WORD = 2'd1,
        OP_READ_SEQ   = 2'd2,
        OP_WRITE_SEQ  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_TX    = 3'd0,
        K_READ  = 3'd1,
        K_DONE  = 3'd2,
        K_ERROR = 3'd3,
        K_NEED  = 3'd4
    } t_kind;

    localparam logic [7:0] CMD_READ_WORD  = 8'h01;
    localparam logic [7:0] CMD_WRITE_WORD = 8'h02;
    localparam logic [7:0] CMD_READ_SEQ   = 8'h03;
    localparam logic [7:0] CMD_WRITE_SEQ  = 8'h04;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One queued job: either a single result, or a byte stream made of one or two
    // words, an optional length byte and an optional data request.
    typedef struct packed {
        logic        single;
        t_kind       kind;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [7:0]  code;
        logic [15:0] idx;
        logic        two_words;
        logic        has_len;
        logic        has_need;
    } t_job;

    function automatic logic [7:0] cmd_byte(input t_op op);
        logic [7:0] b;
        case (op)
            OP_READ_WORD:  b = CMD_READ_WORD;
            OP_WRITE_WORD: b = CMD_WRITE_WORD;
            OP_READ_SEQ:   b = CMD_READ_SEQ;
            OP_WRITE_SEQ:  b = CMD_WRITE_SEQ;
            default:       b = CMD_READ_WORD;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/ubbm_front.sv -----
// Front end: classifies each accepted item against the protocol phase, updates
// the request state and emits one job per item that gives results. Uses ubbm_pkg.
module ubbm_front #(
    parameter int MAX_BURST = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [1:0]        i_mode,
    input  logic [1:0]        i_op,
    input  logic [31:0]       i_address,
    input  logic [15:0]       i_word_count,
    input  logic [31:0]       i_data_word,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output ubbm_pkg::t_job    o_job
);

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_ACK      = 5'b00010,
        PH_RXWORD   = 5'b00100,
        PH_NEEDDATA = 5'b01000,
        PH_STATUS   = 5'b10000
    } t_phase;

    t_phase          r_phase, n_phase;
    ubbm_pkg::t_op   r_op_kind, n_op_kind;
    logic [31:0]     r_base_address, n_base_address;
    logic [31:0]     r_pending_write_word, n_pending_write_word;
    logic [15:0]     r_words_done, n_words_done;
    logic [15:0]     r_words_total, n_words_total;
    logic [8:0]      r_burst_left, n_burst_left;
    logic [1:0]      r_byte_counter, n_byte_counter;
    logic [31:0]     r_word_shift, n_word_shift;

    logic [31:0]     word_addr;
    logic [15:0]     words_left;
    logic [8:0]      burst_len;
    logic [8:0]      burst_len_m1;
    logic [8:0]      burst_dec;
    logic [15:0]     done_inc;
    logic [31:0]     shift_next;
    logic [1:0]      count_next;

    assign word_addr    = r_base_address + {14'd0, r_words_done, 2'b00};
    assign words_left   = r_words_total - r_words_done;
    assign burst_len    = (words_left < 16'(MAX_BURST)) ? words_left[8:0] : 9'(MAX_BURST);
    assign burst_len_m1 = burst_len - 9'd1;
    assign burst_dec    = r_burst_left - 9'd1;
    assign done_inc     = r_words_done + 16'd1;
    assign shift_next   = {i_rx_byte, r_word_shift[31:8]};
    assign count_next   = r_byte_counter + 2'd1;

    always_comb begin
        n_phase              = r_phase;
        n_op_kind            = r_op_kind;
        n_base_address       = r_base_address;
        n_pending_write_word = r_pending_write_word;
        n_words_done         = r_words_done;
        n_words_total        = r_words_total;
        n_burst_left         = r_burst_left;
        n_byte_counter       = r_byte_counter;
        n_word_shift         = r_word_shift;
        o_push               = 1'b0;
        o_job                = '0;

        if (i_take) begin
            case (ubbm_pkg::t_mode'(i_mode))
                ubbm_pkg::MODE_START: begin
                    if (r_phase == PH_IDLE) begin
                        n_op_kind            = ubbm_pkg::t_op'(i_op);
                        n_base_address       = i_address;
                        n_pending_write_word = i_data_word;
                        n_words_done         = 16'd0;
                        n_words_total        = i_op[1] ? i_word_count : 16'd1;
                        n_burst_left         = 9'd0;
                        n_byte_counter       = 2'd0;
                        n_word_shift         = 32'd0;
                        o_push               = 1'b1;
                        o_job.single         = 1'b1;
                        if (n_words_total == 16'd0) begin
                            o_job.kind = ubbm_pkg::K_DONE;
                        end else begin
                            o_job.kind = ubbm_pkg::K_TX;
                            o_job.code = ubbm_pkg::cmd_byte(ubbm_pkg::t_op'(i_op));
                            n_phase    = PH_ACK;
                        end
                    end
                end
                ubbm_pkg::MODE_DATA: begin
                    if (r_phase == PH_NEEDDATA) begin
                        n_pending_write_word = i_data_word;
                        n_words_done         = done_inc;
                        n_burst_left         = burst_dec;
                        o_push               = 1'b1;
                        o_job.w0             = i_data_word;
                        o_job.idx            = done_inc;
                        if (burst_dec == 9'd0) begin
                            n_phase = PH_STATUS;
                        end else begin
                            o_job.has_need = 1'b1;
                        end
                    end
                end
                ubbm_pkg::MODE_RX: begin
                    case (r_phase)
                        PH_ACK: begin
                            o_push = 1'b1;
                            if (i_rx_byte != 8'd0) begin
                                n_phase      = PH_IDLE;
                                o_job.single = 1'b1;
                                o_job.kind   = ubbm_pkg::K_ERROR;
                                o_job.code   = i_rx_byte;
                            end else begin
                                n_byte_counter = 2'd0;
                                n_word_shift   = 32'd0;
                                o_job.w0       = word_addr;
                                case (r_op_kind)
                                    ubbm_pkg::OP_READ_WORD: begin
                                        n_burst_left = 9'd1;
                                        n_phase      = PH_RXWORD;
                                    end
                                    ubbm_pkg::OP_WRITE_WORD: begin
                                        o_job.two_words = 1'b1;
                                        o_job.w1        = r_pending_write_word;
                                        n_words_done    = 16'd1;
                                        n_phase         = PH_STATUS;
                                    end
                                    default: begin
                                        n_burst_left  = burst_len;
                                        o_job.has_len = 1'b1;
                                        o_job.code    = burst_len_m1[7:0];
                                        if (r_op_kind == ubbm_pkg::OP_READ_SEQ) begin
                                            n_phase = PH_RXWORD;
                                        end else begin
                                            n_phase        = PH_NEEDDATA;
                                            o_job.has_need = 1'b1;
                                            o_job.idx      = r_words_done;
                                        end
                                    end
                                endcase
                            end
                        end
                        PH_RXWORD: begin
                            n_word_shift   = shift_next;
                            n_byte_counter = count_next;
                            if (count_next == 2'd0) begin
                                o_push       = 1'b1;
                                o_job.single = 1'b1;
                                o_job.kind   = ubbm_pkg::K_READ;
                                o_job.w0     = shift_next;
                                o_job.idx    = r_words_done;
                                n_words_done = done_inc;
                                n_burst_left = burst_dec;
                                if (burst_dec == 9'd0) begin
                                    n_phase = PH_STATUS;
                                end
                            end
                        end
                        PH_STATUS: begin
                            o_push       = 1'b1;
                            o_job.single = 1'b1;
                            if (i_rx_byte != 8'd0) begin
                                n_phase    = PH_IDLE;
                                o_job.kind = ubbm_pkg::K_ERROR;
                                o_job.code = i_rx_byte;
                            end else if (r_words_done < r_words_total) begin
                                // next burst: repeat the command
                                n_phase    = PH_ACK;
                                o_job.kind = ubbm_pkg::K_TX;
                                o_job.code = ubbm_pkg::cmd_byte(r_op_kind);
                            end else begin
                                n_phase    = PH_IDLE;
                                o_job.kind = ubbm_pkg::K_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase              <= PH_IDLE;
            r_op_kind            <= ubbm_pkg::OP_READ_WORD;
            r_base_address       <= 32'd0;
            r_pending_write_word <= 32'd0;
            r_words_done         <= 16'd0;
            r_words_total        <= 16'd0;
            r_burst_left         <= 9'd0;
            r_byte_counter       <= 2'd0;
            r_word_shift         <= 32'd0;
        end else begin
            r_phase              <= n_phase;
            r_op_kind            <= n_op_kind;
            r_base_address       <= n_base_address;
            r_pending_write_word <= n_pending_write_word;
            r_words_done         <= n_words_done;
            r_words_total        <= n_words_total;
            r_burst_left         <= n_burst_left;
            r_byte_counter       <= n_byte_counter;
            r_word_shift         <= n_word_shift;
        end
    end

endmodule

// ----- rtl/ubbm_queue.sv -----
// Short job queue between the front and back ends.
// Depends on ubbm_pkg for the job type and depth.
module ubbm_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ubbm_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_valid,
    output ubbm_pkg::t_job o_head
);

    ubbm_pkg::t_job                r_mem [ubbm_pkg::QDEPTH];
    logic [ubbm_pkg::QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [ubbm_pkg::QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [ubbm_pkg::QCNT_W-1:0]   r_count, n_count;

    assign o_full  = (r_count == ubbm_pkg::QCNT_W'(ubbm_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ----- rtl/ubbm_back.sv -----
// Back end: expands the job at the queue head into result beats, one per cycle
// while i_stall is low, into a registered output stage. Depends on ubbm_pkg.
module ubbm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ubbm_pkg::t_job i_job,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [2:0]     o_kind,
    output logic [7:0]     o_tx_byte,
    output logic [31:0]    o_read_data,
    output logic [15:0]    o_word_index,
    output logic [7:0]     o_status_code,
    output logic           o_last
);

    localparam logic [3:0] STEP_W0_END = 4'd3;
    localparam logic [3:0] STEP_W1     = 4'd4;
    localparam logic [3:0] STEP_W1_END = 4'd7;
    localparam logic [3:0] STEP_LEN    = 4'd8;
    localparam logic [3:0] STEP_NEED   = 4'd9;

    logic              r_valid;
    logic [3:0]        r_step, n_step;
    ubbm_pkg::t_kind   r_kind;
    logic [7:0]        r_tx_byte;
    logic [31:0]       r_read_data;
    logic [15:0]       r_word_index;
    logic [7:0]        r_status_code;
    logic              r_last;

    ubbm_pkg::t_kind   beat_kind;
    logic [7:0]        beat_byte;
    logic              beat_final;
    logic [31:0]       cur_word;
    logic [31:0]       word_shifted;
    logic              load;

    assign load         = !r_valid || !i_stall;
    assign cur_word     = r_step[2] ? i_job.w1 : i_job.w0;
    assign word_shifted = cur_word >> {r_step[1:0], 3'b000};

    always_comb begin
        beat_kind  = ubbm_pkg::K_TX;
        beat_byte  = i_job.code;
        beat_final = 1'b0;
        n_step     = r_step + 4'd1;
        if (i_job.single) begin
            beat_kind  = i_job.kind;
            beat_final = 1'b1;
        end else begin
            case (r_step)
                STEP_LEN: begin
                    beat_byte = i_job.code;
                    if (i_job.has_need) begin
                        n_step = STEP_NEED;
                    end else begin
                        beat_final = 1'b1;
                    end
                end
                STEP_NEED: begin
                    beat_kind  = ubbm_pkg::K_NEED;
                    beat_final = 1'b1;
                end
                default: begin
                    beat_byte = word_shifted[7:0];
                    if (r_step == STEP_W0_END && i_job.two_words) begin
                        n_step = STEP_W1;
                    end else if (r_step == STEP_W0_END || r_step == STEP_W1_END) begin
                        if (i_job.has_len) begin
                            n_step = STEP_LEN;
                        end else if (i_job.has_need) begin
                            n_step = STEP_NEED;
                        end else begin
                            beat_final = 1'b1;
                        end
                    end
                end
            endcase
        end
        if (beat_final) begin
            n_step = 4'd0;
        end
    end

    assign o_pop = load && i_q_valid && beat_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= 4'd0;
        end else if (load) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_step <= n_step;
            end
        end
    end

    // Payload: clear fields that the beat kind does not use.
    always_ff @(posedge i_clk) begin
        if (load && i_q_valid) begin
            r_kind        <= beat_kind;
            r_tx_byte     <= (beat_kind == ubbm_pkg::K_TX) ? beat_byte : 8'd0;
            r_read_data   <= (beat_kind == ubbm_pkg::K_READ) ? i_job.w0 : 32'd0;
            r_word_index  <= (beat_kind == ubbm_pkg::K_READ || beat_kind == ubbm_pkg::K_NEED)
                             ? i_job.idx : 16'd0;
            r_status_code <= (beat_kind == ubbm_pkg::K_ERROR) ? i_job.code : 8'd0;
            r_last        <= beat_final;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx_byte;
    assign o_read_data   = r_read_data;
    assign o_word_index  = r_word_index;
    assign o_status_code = r_status_code;
    assign o_last        = r_last;

endmodule

// ----- rtl/uart_bus_bridge_master.sv -----
// Top level of the serial bus bridge master: front end, job queue, back end.
// Depends on ubbm_pkg, ubbm_front, ubbm_queue and ubbm_back.
//
//   channel   direction  handshake           payload
//   request   in         i_valid / o_stall   i_mode i_op i_address i_word_count
//                                            i_data_word i_rx_byte
//   result    out        o_valid / i_stall   o_kind o_tx_byte o_read_data
//                                            o_word_index o_status_code o_last
//
// One item is accepted per cycle while the four-entry job queue has room.
// The back end sends one result per cycle while i_stall is low; an item gives 1 to 8
// results, which pass from the job queue through the registered output stage.
// o_stall rises only when the job queue is full; i_stall holds the output register.
// Reset is synchronous and clears the phase, the queue and the output valid.
module uart_bus_bridge_master #(
    parameter int MAX_BURST = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_address,
    input  logic [15:0] i_word_count,
    input  logic [31:0] i_data_word,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [31:0] o_read_data,
    output logic [15:0] o_word_index,
    output logic [7:0]  o_status_code,
    output logic        o_last
);

    logic           take;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_valid;
    ubbm_pkg::t_job push_job;
    ubbm_pkg::t_job head_job;

    assign o_stall = q_full;
    assign take    = i_valid && !q_full;

    ubbm_front #(
        .MAX_BURST (MAX_BURST)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (take),
        .i_mode       (i_mode),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_word_count (i_word_count),
        .i_data_word  (i_data_word),
        .i_rx_byte    (i_rx_byte),
        .o_push       (q_push),
        .o_job        (push_job)
    );

    ubbm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (head_job)
    );

    ubbm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_job         (head_job),
        .o_pop         (q_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_read_data   (o_read_data),
        .o_word_index  (o_word_index),
        .o_status_code (o_status_code),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_error_has_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == ubbm_pkg::K_ERROR |-> o_status_code != 8'd0)
        else $error("error result with zero status");

    a_need_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind == ubbm_pkg::K_NEED |-> o_last)
        else $error("data request not the final result of its item");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid && !(q_push && q_full))
        else $error("job queue pop while empty or push while full");
`endif

endmodule
